/* design/rtt_pkg.sv */
// Shared types and constants for the retry timer table.
package rtt_pkg;

  localparam int NUM_SLOTS  = 16;
  localparam int IDX_W      = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  localparam int ACTION_W   = 2;
  localparam int SLOT_W     = 4;
  localparam int COUNT_W    = 8;
  localparam int MS_W       = 16;
  localparam int TIME_W     = 21;
  localparam int INTERVAL_W = 20;

  localparam logic [INTERVAL_W-1:0] RESET_INTERVAL = INTERVAL_W'(5000);

  typedef enum logic [ACTION_W-1:0] {
    ACT_CALL = 2'd0,
    ACT_ACK  = 2'd1,
    ACT_TICK = 2'd2
  } action_e;

  typedef struct packed {
    logic                armed;
    logic [TIME_W-1:0]   elapsed;
    logic [COUNT_W-1:0]  remaining;
  } entry_t;

  typedef struct packed {
    logic idle;
    logic walking;
    logic pend_valid;
  } stat_t;

endpackage

/* design/rtt_if.sv */
// Channel interfaces: request items, send items and the interval write.
interface rtt_in_if;
  logic                          valid;
  logic                          ready;
  logic [rtt_pkg::ACTION_W-1:0]  action;
  logic [rtt_pkg::SLOT_W-1:0]    slot;
  logic [rtt_pkg::COUNT_W-1:0]   repeat_count;
  logic                          result_ok;
  logic [rtt_pkg::MS_W-1:0]      elapsed_ms;

  modport source (output valid, action, slot, repeat_count, result_ok, elapsed_ms,
                  input ready);
  modport sink (input valid, action, slot, repeat_count, result_ok, elapsed_ms,
                output ready);
endinterface

interface rtt_out_if;
  logic                        valid;
  logic                        ready;
  logic [rtt_pkg::SLOT_W-1:0]  send_slot;
  logic                        is_resend;
  logic                        is_last;

  modport source (output valid, send_slot, is_resend, is_last, input ready);
  modport sink (input valid, send_slot, is_resend, is_last, output ready);
endinterface

interface rtt_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [rtt_pkg::INTERVAL_W-1:0]  retry_interval;

  modport source (output valid, retry_interval, input ready);
  modport sink (input valid, retry_interval, output ready);
endinterface

/* design/rtt_ram.sv */
// Generic simple dual-port RAM with registered read.
module rtt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                         clk_i,
  input  logic                                         we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                             wdata_i,
  input  logic                                         re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                             rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

/* design/rtt_ctrl.sv */
// Sequencer: read-modify-write of the slot table, tick walk and send register.
module rtt_ctrl (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  rtt_in_if.sink                          in_i,
  rtt_out_if.source                       out_o,
  input  logic [rtt_pkg::INTERVAL_W-1:0]  interval_i,
  output rtt_pkg::stat_t                  status_o
);
  localparam int IW = rtt_pkg::IDX_W;
  localparam int N  = rtt_pkg::NUM_SLOTS;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CALL,
    S_ACK,
    S_TICK,
    S_FLUSH
  } state_e;

  state_e                      state_q, state_d;
  logic [IW-1:0]               idx_q, idx_d;
  logic [IW-1:0]               slot_q, slot_d;
  logic [rtt_pkg::MS_W-1:0]    ms_q, ms_d;
  logic                        pend_vld_q, pend_vld_d;
  logic [IW-1:0]               pend_idx_q, pend_idx_d;
  logic [N-1:0]                vld_q, vld_d;
  logic                        rd_vld_q, rd_vld_d;
  logic                        out_vld_q, out_vld_d;
  logic [rtt_pkg::SLOT_W-1:0]  out_slot_q, out_slot_d;
  logic                        out_resend_q, out_resend_d;
  logic                        out_last_q, out_last_d;

  logic                        ram_we;
  logic [IW-1:0]               ram_waddr;
  rtt_pkg::entry_t             ram_wdata;
  logic                        ram_re;
  logic [IW-1:0]               ram_raddr;
  logic [$bits(rtt_pkg::entry_t)-1:0] ram_rdata;

  rtt_pkg::entry_t             cur;
  logic [rtt_pkg::TIME_W:0]    sum;
  logic [rtt_pkg::TIME_W-1:0]  t_sat;
  logic                        due;
  logic                        out_free;
  logic                        slot_ok;
  logic                        last_idx;

  rtt_ram #(
    .WIDTH ($bits(rtt_pkg::entry_t)),
    .DEPTH (N)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // A slot never written reads as all zero
  assign cur      = rd_vld_q ? rtt_pkg::entry_t'(ram_rdata) : '0;
  assign sum      = {1'b0, cur.elapsed} + (rtt_pkg::TIME_W + 1)'(ms_q);
  assign t_sat    = sum[rtt_pkg::TIME_W] ? '1 : sum[rtt_pkg::TIME_W-1:0];
  assign due      = cur.armed && (t_sat >= rtt_pkg::TIME_W'(interval_i));
  assign out_free = !out_vld_q || out_o.ready;
  assign slot_ok  = in_i.slot <= rtt_pkg::SLOT_W'(N - 1);
  assign last_idx = idx_q == IW'(N - 1);

  assign in_i.ready      = state_q == S_IDLE;
  assign out_o.valid     = out_vld_q;
  assign out_o.send_slot = out_slot_q;
  assign out_o.is_resend = out_resend_q;
  assign out_o.is_last   = out_last_q;

  assign status_o.idle       = state_q == S_IDLE;
  assign status_o.walking    = (state_q == S_TICK) || (state_q == S_FLUSH);
  assign status_o.pend_valid = pend_vld_q;

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    slot_d       = slot_q;
    ms_d         = ms_q;
    pend_vld_d   = pend_vld_q;
    pend_idx_d   = pend_idx_q;
    vld_d        = vld_q;
    rd_vld_d     = rd_vld_q;
    out_vld_d    = out_vld_q && !out_o.ready;
    out_slot_d   = out_slot_q;
    out_resend_d = out_resend_q;
    out_last_d   = out_last_q;
    ram_we       = 1'b0;
    ram_waddr    = idx_q;
    ram_wdata    = cur;
    ram_re       = 1'b0;
    ram_raddr    = idx_q;

    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          case (in_i.action)
            rtt_pkg::ACT_CALL: begin
              if (slot_ok) begin
                ram_we              = 1'b1;
                ram_waddr           = IW'(in_i.slot);
                ram_wdata.armed     = 1'b1;
                ram_wdata.elapsed   = '0;
                ram_wdata.remaining = in_i.repeat_count;
                vld_d[IW'(in_i.slot)] = 1'b1;
                slot_d              = IW'(in_i.slot);
                state_d             = S_CALL;
              end
            end
            rtt_pkg::ACT_ACK: begin
              if (slot_ok && in_i.result_ok) begin
                ram_re    = 1'b1;
                ram_raddr = IW'(in_i.slot);
                rd_vld_d  = vld_q[IW'(in_i.slot)];
                slot_d    = IW'(in_i.slot);
                state_d   = S_ACK;
              end
            end
            rtt_pkg::ACT_TICK: begin
              ram_re     = 1'b1;
              ram_raddr  = '0;
              rd_vld_d   = vld_q[0];
              idx_d      = '0;
              ms_d       = in_i.elapsed_ms;
              pend_vld_d = 1'b0;
              state_d    = S_TICK;
            end
            default: ;
          endcase
        end
      end
      S_CALL: begin
        if (out_free) begin
          out_vld_d    = 1'b1;
          out_slot_d   = rtt_pkg::SLOT_W'(slot_q);
          out_resend_d = 1'b0;
          out_last_d   = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_ACK: begin
        ram_we    = 1'b1;
        ram_waddr = slot_q;
        vld_d[slot_q] = 1'b1;
        if (cur.remaining > rtt_pkg::COUNT_W'(1)) begin
          ram_wdata.remaining = cur.remaining - rtt_pkg::COUNT_W'(1);
        end else begin
          ram_wdata = '0;
        end
        state_d = S_IDLE;
      end
      S_TICK: begin
        // Hold the walk while an earlier due slot cannot move to the send register
        if (!(due && pend_vld_q && !out_free)) begin
          if (cur.armed) begin
            ram_we            = 1'b1;
            ram_waddr         = idx_q;
            ram_wdata.elapsed = due ? '0 : t_sat;
            vld_d[idx_q]      = 1'b1;
          end
          if (due) begin
            if (pend_vld_q) begin
              out_vld_d    = 1'b1;
              out_slot_d   = rtt_pkg::SLOT_W'(pend_idx_q);
              out_resend_d = 1'b1;
              out_last_d   = 1'b0;
            end
            pend_vld_d = 1'b1;
            pend_idx_d = idx_q;
          end
          if (last_idx) begin
            state_d = S_FLUSH;
          end else begin
            idx_d     = idx_q + IW'(1);
            ram_re    = 1'b1;
            ram_raddr = idx_q + IW'(1);
            rd_vld_d  = vld_q[idx_q + IW'(1)];
          end
        end
      end
      S_FLUSH: begin
        if (!pend_vld_q) begin
          state_d = S_IDLE;
        end else if (out_free) begin
          out_vld_d    = 1'b1;
          out_slot_d   = rtt_pkg::SLOT_W'(pend_idx_q);
          out_resend_d = 1'b1;
          out_last_d   = 1'b1;
          pend_vld_d   = 1'b0;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      idx_q        <= '0;
      slot_q       <= '0;
      ms_q         <= '0;
      pend_vld_q   <= 1'b0;
      pend_idx_q   <= '0;
      vld_q        <= '0;
      rd_vld_q     <= 1'b0;
      out_vld_q    <= 1'b0;
      out_slot_q   <= '0;
      out_resend_q <= 1'b0;
      out_last_q   <= 1'b0;
    end else begin
      state_q      <= state_d;
      idx_q        <= idx_d;
      slot_q       <= slot_d;
      ms_q         <= ms_d;
      pend_vld_q   <= pend_vld_d;
      pend_idx_q   <= pend_idx_d;
      vld_q        <= vld_d;
      rd_vld_q     <= rd_vld_d;
      out_vld_q    <= out_vld_d;
      out_slot_q   <= out_slot_d;
      out_resend_q <= out_resend_d;
      out_last_q   <= out_last_d;
    end
  end
endmodule

/* design/retry_timer_table.sv */
// Retry timer table top level: interval register, sequencer and checks.
// Items are taken only while idle; a call goes to S_CALL, which loads its send item
// once the send register is free, an acknowledge to S_ACK; a tick walks one slot a
// cycle, held while the send register is full, via the single read port of the RAM.
// Reset: every slot reads as unarmed with zero time and count (per-slot valid bits),
// retry_interval returns to 5000; no clearing pass is needed.
module retry_timer_table (
  input  logic       clk_i,
  input  logic       rst_ni,
  rtt_in_if.sink     in_i,
  rtt_out_if.source  out_o,
  rtt_cfg_if.sink    cfg_i
);
  logic [rtt_pkg::INTERVAL_W-1:0] interval_q;
  rtt_pkg::stat_t                 status;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= rtt_pkg::RESET_INTERVAL;
    end else if (cfg_i.valid) begin
      interval_q <= cfg_i.retry_interval;
    end
  end

  rtt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .out_o      (out_o),
    .interval_i (interval_q),
    .status_o   (status)
  );

  a_first_send_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.is_resend |-> out_o.is_last)
    else $error("first send not marked last");

  a_tick_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready && (in_i.action == rtt_pkg::ACT_TICK) |=> !in_i.ready)
    else $error("input taken during tick walk");

  a_pend_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.pend_valid |-> status.walking)
    else $error("pending resend outside tick walk");

  a_idle_no_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.idle |-> !status.pend_valid)
    else $error("pending resend held while idle");
endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the retry timer table: predicted send items against the block.
module testbench;

  localparam logic [rtt_pkg::ACTION_W-1:0] ACT_UNUSED = 2'd3;
  localparam logic [rtt_pkg::TIME_W-1:0] TIME_MAX = '1;
  localparam int CYCLE_LIMIT = 500000;
  localparam int SETTLE_CYCLES = rtt_pkg::NUM_SLOTS + 8;

  typedef struct packed {
    logic [rtt_pkg::SLOT_W-1:0] send_slot;
    logic                       is_resend;
    logic                       is_last;
  } send_t;

  logic clk = 1'b0;
  logic rst_n;

  rtt_in_if  in_ch ();
  rtt_out_if out_ch ();
  rtt_cfg_if cfg_ch ();

  retry_timer_table u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  always #5 clk = ~clk;

  // Predicted slot table and interval register
  logic                           slot_armed [rtt_pkg::NUM_SLOTS];
  logic [rtt_pkg::TIME_W-1:0]     slot_time [rtt_pkg::NUM_SLOTS];
  logic [rtt_pkg::COUNT_W-1:0]    slot_count [rtt_pkg::NUM_SLOTS];
  logic [rtt_pkg::INTERVAL_W-1:0] interval_q;

  send_t pending_sends[$];

  int err_count = 0;
  int n_items = 0;
  int n_sends = 0;
  int n_writes = 0;
  int cycle_count = 0;
  bit no_gaps = 1'b0;

  task automatic report_mismatch(string msg);
    err_count++;
    $display("%0d ns  %s", $time, msg);
  endtask

  // Work out the send items that one accepted request item causes
  function automatic void predict_sends(logic [rtt_pkg::ACTION_W-1:0] act,
                                        logic [rtt_pkg::SLOT_W-1:0] slot,
                                        logic [rtt_pkg::COUNT_W-1:0] count, logic ok,
                                        logic [rtt_pkg::MS_W-1:0] ms);
    logic [rtt_pkg::TIME_W:0] sum;
    bit due [rtt_pkg::NUM_SLOTS];
    int last_due;
    last_due = -1;
    case (act)
      rtt_pkg::ACT_CALL: begin
        if (slot < rtt_pkg::NUM_SLOTS) begin
          slot_armed[slot] = 1'b1;
          slot_time[slot] = '0;
          slot_count[slot] = count;
          pending_sends.push_back('{slot, 1'b0, 1'b1});
        end
      end
      rtt_pkg::ACT_ACK: begin
        if (slot < rtt_pkg::NUM_SLOTS && ok) begin
          if (slot_count[slot] > 1) begin
            slot_count[slot] = slot_count[slot] - 1'b1;
          end else begin
            slot_armed[slot] = 1'b0;
            slot_count[slot] = '0;
          end
        end
      end
      rtt_pkg::ACT_TICK: begin
        for (int i = 0; i < rtt_pkg::NUM_SLOTS; i++) begin
          due[i] = 1'b0;
          if (slot_armed[i]) begin
            sum = {1'b0, slot_time[i]} + ms;
            if (sum > {1'b0, TIME_MAX}) sum = {1'b0, TIME_MAX};
            if (sum >= interval_q) begin
              due[i] = 1'b1;
              last_due = i;
              sum = '0;
            end
            slot_time[i] = sum[rtt_pkg::TIME_W-1:0];
          end
        end
        for (int i = 0; i < rtt_pkg::NUM_SLOTS; i++) begin
          if (due[i]) begin
            pending_sends.push_back('{rtt_pkg::SLOT_W'(i), 1'b1, 1'(i == last_due)});
          end
        end
      end
      default: ;
    endcase
  endfunction

  task automatic send_item(logic [rtt_pkg::ACTION_W-1:0] act,
                           logic [rtt_pkg::SLOT_W-1:0] slot,
                           logic [rtt_pkg::COUNT_W-1:0] count, logic ok,
                           logic [rtt_pkg::MS_W-1:0] ms);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.action <= act;
    in_ch.slot <= slot;
    in_ch.repeat_count <= count;
    in_ch.result_ok <= ok;
    in_ch.elapsed_ms <= ms;
    do @(posedge clk); while (!in_ch.ready);
    predict_sends(act, slot, count, ok, ms);
    n_items++;
  endtask

  // Unused fields carry noise
  task automatic call_slot(int slot, int count);
    send_item(rtt_pkg::ACT_CALL, rtt_pkg::SLOT_W'(slot), rtt_pkg::COUNT_W'(count),
              1'($urandom), rtt_pkg::MS_W'($urandom));
  endtask

  task automatic ack_slot(int slot, bit ok);
    send_item(rtt_pkg::ACT_ACK, rtt_pkg::SLOT_W'(slot), rtt_pkg::COUNT_W'($urandom), ok,
              rtt_pkg::MS_W'($urandom));
  endtask

  task automatic tick(int ms);
    send_item(rtt_pkg::ACT_TICK, rtt_pkg::SLOT_W'($urandom), rtt_pkg::COUNT_W'($urandom),
              1'($urandom), rtt_pkg::MS_W'(ms));
  endtask

  // Drop valid, wait for every send item, then let any tick walk finish
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending_sends.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_interval(int value);
    settle();
    cfg_ch.valid <= 1'b1;
    cfg_ch.retry_interval <= rtt_pkg::INTERVAL_W'(value);
    do @(posedge clk); while (!cfg_ch.ready);
    interval_q = rtt_pkg::INTERVAL_W'(value);
    n_writes++;
    cfg_ch.valid <= 1'b0;
  endtask

  // Elapsed times scaled to the interval so that resends happen often
  function automatic int tick_ms();
    if ($urandom_range(0, 3) == 0 || interval_q > 65535) return $urandom_range(0, 65535);
    return $urandom_range(0, interval_q);
  endfunction

  task automatic random_item();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      call_slot($urandom_range(0, 15),
                ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 3));
    end else if (pick < 60) begin
      ack_slot($urandom_range(0, 15), $urandom_range(0, 4) != 0);
    end else if (pick < 96) begin
      tick(tick_ms());
    end else begin
      send_item(ACT_UNUSED, rtt_pkg::SLOT_W'($urandom), rtt_pkg::COUNT_W'($urandom),
                1'($urandom), rtt_pkg::MS_W'($urandom));
    end
  endtask

  task automatic test_directed();
    call_slot(0, 2);
    call_slot(15, 0);
    tick(4999);
    tick(1);
    ack_slot(0, 1'b0);
    ack_slot(0, 1'b1);
    tick(5000);
    ack_slot(0, 1'b1);
    ack_slot(15, 1'b1);
    ack_slot(7, 1'b1);
    tick(65535);
    send_item(ACT_UNUSED, '1, '1, 1'b1, '1);
    call_slot(3, 255);
    tick(3000);
    call_slot(3, 255);
    tick(3000);
    tick(2000);
    ack_slot(3, 1'b1);
    tick(0);
  endtask

  task automatic test_zero_interval();
    write_interval(0);
    call_slot(5, 1);
    call_slot(9, 1);
    tick(0);
    ack_slot(5, 1'b1);
    ack_slot(9, 1'b1);
    tick(0);
  endtask

  task automatic test_interval_extremes();
    int values [4];
    values = '{1, 1000000, (1 << rtt_pkg::INTERVAL_W) - 1,
               $urandom_range(1, 1 << rtt_pkg::INTERVAL_W)};
    foreach (values[k]) begin
      write_interval(values[k]);
      no_gaps = (k == 1);
      repeat (40) random_item();
    end
    no_gaps = 1'b0;
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: write_interval($urandom_range(100, 3000));
        1: write_interval($urandom_range(1, 20000));
        default: write_interval($urandom_range(1, (1 << rtt_pkg::INTERVAL_W) - 1));
      endcase
      repeat (60) random_item();
      no_gaps = 1'b1;
      repeat (40) random_item();
      no_gaps = 1'b0;
    end
  endtask

  // Receiver: stall a random number of cycles before each send item
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge rst_n);
    @(posedge clk);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  always @(posedge clk) begin
    send_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      n_sends++;
      if (pending_sends.size() == 0) begin
        report_mismatch($sformatf("send item for slot %0d with none expected",
                                  out_ch.send_slot));
      end else begin
        want = pending_sends.pop_front();
        if (out_ch.send_slot !== want.send_slot)
          report_mismatch($sformatf("send_slot %0d, expected %0d",
                                    out_ch.send_slot, want.send_slot));
        if (out_ch.is_resend !== want.is_resend)
          report_mismatch($sformatf("is_resend %0b, expected %0b for slot %0d",
                                    out_ch.is_resend, want.is_resend, want.send_slot));
        if (out_ch.is_last !== want.is_last)
          report_mismatch($sformatf("is_last %0b, expected %0b for slot %0d",
                                    out_ch.is_last, want.is_last, want.send_slot));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timed out after %0d cycles", cycle_count);
      $display("retry_timer_table: mismatch");
      $finish;
    end
  end

  initial begin
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.action <= rtt_pkg::ACT_CALL;
    in_ch.slot <= '0;
    in_ch.repeat_count <= '0;
    in_ch.result_ok <= 1'b0;
    in_ch.elapsed_ms <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.retry_interval <= '0;
    for (int i = 0; i < rtt_pkg::NUM_SLOTS; i++) begin
      slot_armed[i] = 1'b0;
      slot_time[i] = '0;
      slot_count[i] = '0;
    end
    interval_q = rtt_pkg::RESET_INTERVAL;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_zero_interval();
    test_interval_extremes();
    test_random_traffic();
    settle();

    $display("%0d request items sent, %0d send items checked", n_items, n_sends);
    $display("%0d interval writes, extremes and zero included", n_writes);
    if (err_count == 0) begin
      $display("retry_timer_table: match");
    end else begin
      $display("retry_timer_table: mismatch");
    end
    $finish;
  end

endmodule
